[sv/seof_pkg.sv]
// Shared types and constants for the staggered-entry occupancy forward block.
// Used by seof_ctrl, seof_datapath and staggered_entry_occupancy_forward.
`default_nettype none

package seof_pkg;

    // Default field formats: probabilities Q1.15 in 16 bits, masses Q1.31 in 32 bits.
    localparam int PROB_BITS_DEF = 16;
    localparam int MASS_BITS_DEF = 32;

    // The likelihood result and the floor register are always 32 bits wide.
    localparam int LIKE_BITS = 32;
    localparam logic [LIKE_BITS-1:0] FLOOR_RESET = 32'd1;

    // Observation codes; the spare code behaves as a missing survey.
    localparam logic [1:0] OBS_NOT_DETECTED = 2'd0;
    localparam logic [1:0] OBS_DETECTED     = 2'd1;
    localparam logic [1:0] OBS_MISSING      = 2'd2;

    // Datapath commands issued by the controller, one per cycle.
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_MUL_M0,
        CMD_MUL_M1,
        CMD_SUM,
        CMD_MUL_DET,
        CMD_APPLY,
        CMD_SEAS_SUM,
        CMD_MIX0,
        CMD_MIX1,
        CMD_MIX2,
        CMD_EMIT
    } t_dp_cmd;

    // Status returned from the datapath to the controller.
    typedef struct packed {
        logic season_end;
        logic site_end;
    } t_dp_status;

endpackage

`default_nettype wire

[sv/staggered_entry_occupancy_forward.sv]
// Top level of the staggered-entry occupancy forward likelihood block.
// Instantiates seof_ctrl and seof_datapath; depends on seof_pkg.
`default_nettype none

// One input transfer is one survey of a site; one output transfer carries the
// floored likelihood of a site and is produced on the survey marked by tlast.
// Surveys are taken one at a time: each is loaded, goes through the stage
// transition and detection, and then tready returns; one that ends a season
// adds the season sum and the mix, and one that ends the site adds the season
// sum and a wait until a previous result has been taken. The steps follow the
// chain of dependent products on the two shared multipliers (stage transition,
// then detection, then the colonisation and extinction mix). A finished result
// waits in an output register, so the next survey is accepted while it is still
// pending. The floor register may be written only while the block is idle.
module staggered_entry_occupancy_forward #(
    parameter int PROB_BITS = seof_pkg::PROB_BITS_DEF,
    parameter int MASS_BITS = seof_pkg::MASS_BITS_DEF,
    localparam int IN_DATA_W = ((6 * PROB_BITS + 2 + 7) / 8) * 8
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    // Survey stream.
    input  wire                            s_axis_tvalid,
    output logic                           s_axis_tready,
    // initial_occupancy, enter_prob, depart_prob, detect_prob, observation,
    // colonize_prob, extinct_prob, zero padding
    input  wire [IN_DATA_W-1:0]            s_axis_tdata,
    // first_of_site, last_of_season
    input  wire [1:0]                      s_axis_tuser,
    // last_of_site
    input  wire                            s_axis_tlast,
    // Result stream.
    output logic                           m_axis_tvalid,
    input  wire                            m_axis_tready,
    // site_likelihood
    output logic [seof_pkg::LIKE_BITS-1:0] m_axis_tdata,
    // floored
    output logic                           m_axis_tuser,
    // Floor register write.
    input  wire                            i_cfg_we,
    input  wire [seof_pkg::LIKE_BITS-1:0]  i_cfg_wdata
);

    localparam int P = PROB_BITS;

    seof_pkg::t_dp_cmd    cmd;
    seof_pkg::t_dp_status status;

    // Sequencer and handshakes.
    seof_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // Arithmetic and state, with the survey fields unpacked from tdata.
    seof_datapath #(
        .PROB_BITS (PROB_BITS),
        .MASS_BITS (MASS_BITS)
    ) u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_status            (status),
        .i_first_of_site     (s_axis_tuser[0]),
        .i_initial_occupancy (s_axis_tdata[0 +: P]),
        .i_enter_prob        (s_axis_tdata[P +: P]),
        .i_depart_prob       (s_axis_tdata[2*P +: P]),
        .i_detect_prob       (s_axis_tdata[3*P +: P]),
        .i_observation       (s_axis_tdata[4*P +: 2]),
        .i_last_of_season    (s_axis_tuser[1]),
        .i_last_of_site      (s_axis_tlast),
        .i_colonize_prob     (s_axis_tdata[4*P+2 +: P]),
        .i_extinct_prob      (s_axis_tdata[5*P+2 +: P]),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_wdata         (i_cfg_wdata),
        .o_site_likelihood   (m_axis_tdata),
        .o_floored           (m_axis_tuser)
    );

`ifndef SYNTHESIS
    // A survey is worked on alone: no second transfer in the following cycle.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("survey accepted while the previous one is still in work");

    // A result is only written into a free output register.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd == seof_pkg::CMD_EMIT) |-> (!m_axis_tvalid || m_axis_tready))
        else $error("pending result overwritten");

    // A result is only produced for a survey that ends the site.
    a_emit_on_site_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd == seof_pkg::CMD_EMIT) |-> status.site_end)
        else $error("result produced without a site end");
`endif

endmodule

`default_nettype wire

[sv/seof_datapath.sv]
// Datapath of the occupancy forward block: stage masses, two shared multipliers,
// saturating adders, floor register and result registers. Depends on seof_pkg.
`default_nettype none

module seof_datapath #(
    parameter int PROB_BITS = seof_pkg::PROB_BITS_DEF,
    parameter int MASS_BITS = seof_pkg::MASS_BITS_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  seof_pkg::t_dp_cmd              i_cmd,
    output seof_pkg::t_dp_status           o_status,
    input  wire                            i_first_of_site,
    input  wire [PROB_BITS-1:0]            i_initial_occupancy,
    input  wire [PROB_BITS-1:0]            i_enter_prob,
    input  wire [PROB_BITS-1:0]            i_depart_prob,
    input  wire [PROB_BITS-1:0]            i_detect_prob,
    input  wire [1:0]                      i_observation,
    input  wire                            i_last_of_season,
    input  wire                            i_last_of_site,
    input  wire [PROB_BITS-1:0]            i_colonize_prob,
    input  wire [PROB_BITS-1:0]            i_extinct_prob,
    input  wire                            i_cfg_we,
    input  wire [seof_pkg::LIKE_BITS-1:0]  i_cfg_wdata,
    output logic [seof_pkg::LIKE_BITS-1:0] o_site_likelihood,
    output logic                           o_floored
);

    localparam int P     = PROB_BITS;
    localparam int M     = MASS_BITS;
    localparam int LW    = seof_pkg::LIKE_BITS;
    localparam int MP_W  = M + P;
    localparam int UP_SH = (M >= P) ? (M - P) : 0;
    localparam int DN_SH = (P > M) ? (P - M) : 0;
    localparam int CMP_W = (M > LW) ? M : LW;

    localparam logic [P-1:0]    ONE_P = P'(1) << (P - 1);
    localparam logic [M-1:0]    ONE_M = M'(1) << (M - 1);
    localparam logic [MP_W-1:0] HALF  = MP_W'(1) << (P - 2);

    // Saturating sum of two masses, limited to 1.0.
    function automatic logic [M-1:0] sat_add(input logic [M-1:0] a, input logic [M-1:0] b);
        logic [M:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, ONE_M}) ? ONE_M : s[M-1:0];
    endfunction

    // Probabilities above 1.0 are taken as 1.0.
    function automatic logic [P-1:0] clamp_p(input logic [P-1:0] v);
        return (v > ONE_P) ? ONE_P : v;
    endfunction

    // Stage masses and survey state.
    logic [M-1:0] r_m0, r_m1, r_m2, r_unocc;
    logic         r_seen, r_at_start;
    // Captured survey fields, already clamped and forced.
    logic [P-1:0] r_e, r_d, r_p, r_col, r_ext;
    logic [1:0]   r_obs;
    logic         r_season_end, r_site_end;
    // Product and temporary registers.
    logic [M-1:0] r_pa, r_pb, r_t, r_s1;
    logic [LW-1:0] r_floor;

    logic [M-1:0]    mul_a_m, mul_b_m;
    logic [P-1:0]    mul_a_p, mul_b_p;
    logic [MP_W-1:0] prod_a, prod_b;
    logic [MP_W-1:0] psi_wide;
    logic [M-1:0]    psi;
    logic [P-1:0]    e_clamped, d_clamped;
    logic [M-1:0]    like;
    logic            like_low;

    assign o_status.season_end = r_season_end;
    assign o_status.site_end   = r_site_end;

    // Initial occupancy moved into the mass format.
    assign psi_wide = (MP_W'(clamp_p(i_initial_occupancy)) << UP_SH) >> DN_SH;
    assign psi      = psi_wide[M-1:0];

    // Entry is forced on a season end; departure is blocked at a season start.
    assign e_clamped = (i_last_of_season || i_last_of_site) ? ONE_P : clamp_p(i_enter_prob);
    assign d_clamped = (i_first_of_site || r_at_start) ? '0 : clamp_p(i_depart_prob);

    // Operand selection for the two shared multipliers.
    always_comb begin
        mul_a_m = r_m0;
        mul_a_p = ONE_P - r_e;
        mul_b_m = r_m0;
        mul_b_p = r_e;
        case (i_cmd)
            seof_pkg::CMD_MUL_M1: begin
                mul_a_m = r_m1;
                mul_a_p = ONE_P - r_d;
                mul_b_m = r_m1;
                mul_b_p = r_d;
            end
            seof_pkg::CMD_MUL_DET: begin
                mul_a_m = r_m1;
                mul_a_p = (r_obs == seof_pkg::OBS_DETECTED) ? r_p : (ONE_P - r_p);
            end
            seof_pkg::CMD_MIX0: begin
                mul_a_m = r_t;
                mul_a_p = ONE_P - r_ext;
                mul_b_m = r_s1;
                mul_b_p = r_col;
            end
            seof_pkg::CMD_MIX1: begin
                mul_a_m = r_t;
                mul_a_p = r_ext;
                mul_b_m = r_s1;
                mul_b_p = ONE_P - r_col;
            end
            default: begin
            end
        endcase
    end

    // Mass times probability, rounded half up.
    assign prod_a = MP_W'(mul_a_m) * MP_W'(mul_a_p) + HALF;
    assign prod_b = MP_W'(mul_b_m) * MP_W'(mul_b_p) + HALF;

    // Likelihood and floor comparison.
    assign like     = sat_add(r_t, r_s1);
    assign like_low = CMP_W'(like) < CMP_W'(r_floor);

    // Floor register; the user must write it only while the block is idle, as the block does not enforce this.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floor <= seof_pkg::FLOOR_RESET;
        end else if (i_cfg_we) begin
            r_floor <= i_cfg_wdata;
        end
    end

    // Product registers.
    always_ff @(posedge i_clk) begin
        r_pa <= prod_a[P-1 +: M];
        r_pb <= prod_b[P-1 +: M];
    end

    // Result registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd == seof_pkg::CMD_EMIT) begin
            o_site_likelihood <= like_low ? r_floor : LW'(like);
            o_floored         <= like_low;
        end
    end

    // Survey state and mass updates, one command per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m0         <= '0;
            r_m1         <= '0;
            r_m2         <= '0;
            r_unocc      <= '0;
            r_seen       <= 1'b0;
            r_at_start   <= 1'b1;
            r_e          <= '0;
            r_d          <= '0;
            r_p          <= '0;
            r_col        <= '0;
            r_ext        <= '0;
            r_obs        <= seof_pkg::OBS_MISSING;
            r_season_end <= 1'b0;
            r_site_end   <= 1'b0;
            r_t          <= '0;
            r_s1         <= '0;
        end else begin
            case (i_cmd)
                seof_pkg::CMD_LOAD: begin
                    r_e          <= e_clamped;
                    r_d          <= d_clamped;
                    r_p          <= clamp_p(i_detect_prob);
                    r_col        <= clamp_p(i_colonize_prob);
                    r_ext        <= clamp_p(i_extinct_prob);
                    r_obs        <= i_observation;
                    r_season_end <= i_last_of_season || i_last_of_site;
                    r_site_end   <= i_last_of_site;
                    if (i_first_of_site) begin
                        r_m0       <= psi;
                        r_m1       <= '0;
                        r_m2       <= '0;
                        r_unocc    <= ONE_M - psi;
                        r_seen     <= 1'b0;
                        r_at_start <= 1'b1;
                    end
                end
                seof_pkg::CMD_MUL_M1: begin
                    r_m0 <= r_pa;
                    r_t  <= r_pb;
                end
                seof_pkg::CMD_SUM: begin
                    r_m1 <= sat_add(r_t, r_pa);
                    r_m2 <= sat_add(r_pb, r_m2);
                end
                seof_pkg::CMD_APPLY: begin
                    r_at_start <= 1'b0;
                    if (r_obs == seof_pkg::OBS_DETECTED) begin
                        r_m0   <= '0;
                        r_m1   <= r_pa;
                        r_m2   <= '0;
                        r_seen <= 1'b1;
                    end else if (r_obs == seof_pkg::OBS_NOT_DETECTED) begin
                        r_m1 <= r_pa;
                    end
                end
                seof_pkg::CMD_SEAS_SUM: begin
                    r_t  <= sat_add(sat_add(r_m0, r_m1), r_m2);
                    r_s1 <= r_seen ? '0 : r_unocc;
                end
                seof_pkg::CMD_MIX1: begin
                    r_m0 <= sat_add(r_pa, r_pb);
                end
                seof_pkg::CMD_MIX2: begin
                    r_unocc    <= sat_add(r_pa, r_pb);
                    r_m1       <= '0;
                    r_m2       <= '0;
                    r_seen     <= 1'b0;
                    r_at_start <= 1'b1;
                end
                seof_pkg::CMD_EMIT: begin
                    r_m0       <= '0;
                    r_m1       <= '0;
                    r_m2       <= '0;
                    r_unocc    <= '0;
                    r_seen     <= 1'b0;
                    r_at_start <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[sv/seof_ctrl.sv]
// Controller of the occupancy forward block: sequences one survey through the
// datapath and owns the input and output handshakes. Depends on seof_pkg.
`default_nettype none

module seof_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    input  seof_pkg::t_dp_status i_status,
    output seof_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_M0,
        S_MUL_M1,
        S_SUM,
        S_MUL_DET,
        S_APPLY,
        S_SEAS_SUM,
        S_MIX0,
        S_MIX1,
        S_MIX2,
        S_EMIT
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   slot_free;

    // No survey is taken while reset is held.
    assign o_in_ready  = (r_state == S_IDLE) && i_rst_n;
    assign o_out_valid = r_out_valid;
    assign slot_free   = !r_out_valid || i_out_ready;

    // Command decode and next-state logic.
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = seof_pkg::CMD_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    o_cmd   = seof_pkg::CMD_LOAD;
                    n_state = S_MUL_M0;
                end
            end
            S_MUL_M0: begin
                o_cmd   = seof_pkg::CMD_MUL_M0;
                n_state = S_MUL_M1;
            end
            S_MUL_M1: begin
                o_cmd   = seof_pkg::CMD_MUL_M1;
                n_state = S_SUM;
            end
            S_SUM: begin
                o_cmd   = seof_pkg::CMD_SUM;
                n_state = S_MUL_DET;
            end
            S_MUL_DET: begin
                o_cmd   = seof_pkg::CMD_MUL_DET;
                n_state = S_APPLY;
            end
            S_APPLY: begin
                o_cmd   = seof_pkg::CMD_APPLY;
                n_state = i_status.season_end ? S_SEAS_SUM : S_IDLE;
            end
            S_SEAS_SUM: begin
                o_cmd   = seof_pkg::CMD_SEAS_SUM;
                n_state = i_status.site_end ? S_EMIT : S_MIX0;
            end
            S_MIX0: begin
                o_cmd   = seof_pkg::CMD_MIX0;
                n_state = S_MIX1;
            end
            S_MIX1: begin
                o_cmd   = seof_pkg::CMD_MIX1;
                n_state = S_MIX2;
            end
            S_MIX2: begin
                o_cmd   = seof_pkg::CMD_MIX2;
                n_state = S_IDLE;
            end
            S_EMIT: begin
                // Wait here until the result register can take a new value.
                if (slot_free) begin
                    o_cmd       = seof_pkg::CMD_EMIT;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and output-valid register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire
